[rtl/core/tshp_pkg.sv]
// Shared types and constants for the ServerHello body parser.
// Holds the beat structs, phase and code enums, and the layout constants.
`timescale 1ns / 1ps

package tshp_pkg;

  // Layout of the ServerHello body
  localparam logic [7:0]  MAX_SESSION_ID = 8'd32;
  localparam logic [15:0] RANDOM_LEN     = 16'd28;
  localparam logic [15:0] VERSION_BYTES  = 16'd2;
  localparam logic [15:0] TIME_BYTES     = 16'd4;
  localparam logic [15:0] CIPHER_BYTES   = 16'd2;
  localparam logic [15:0] EXTLEN_BYTES   = 16'd2;
  localparam logic [15:0] EXTHDR_BYTES   = 16'd4;
  localparam logic [15:0] EXTHDR_LEN_POS = 16'd2;
  localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;

  // Cipher suites recognized as known
  localparam logic [15:0] CIPHER_RC4_SHA    = 16'h0005;
  localparam logic [15:0] CIPHER_AES128_SHA = 16'h002F;
  localparam logic [15:0] CIPHER_AES256_SHA = 16'h0035;

  typedef enum logic [3:0] {
    FLD_VERSION  = 4'd0,
    FLD_TIME     = 4'd1,
    FLD_RANDOM   = 4'd2,
    FLD_SIDLEN   = 4'd3,
    FLD_SID      = 4'd4,
    FLD_CIPHER   = 4'd5,
    FLD_COMP     = 4'd6,
    FLD_EXTLEN   = 4'd7,
    FLD_EXTHDR   = 4'd8,
    FLD_EXTBODY  = 4'd9,
    FLD_EXCESS   = 4'd10
  } field_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_SID_LONG  = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_EXT_LEN   = 2'd3
  } status_e;

  typedef enum logic [10:0] {
    PH_VERSION = 11'b000_0000_0001,
    PH_TIME    = 11'b000_0000_0010,
    PH_RANDOM  = 11'b000_0000_0100,
    PH_SIDLEN  = 11'b000_0000_1000,
    PH_SID     = 11'b000_0001_0000,
    PH_CIPHER  = 11'b000_0010_0000,
    PH_COMP    = 11'b000_0100_0000,
    PH_EXTLEN  = 11'b000_1000_0000,
    PH_EXTHDR  = 11'b001_0000_0000,
    PH_EXTBODY = 11'b010_0000_0000,
    PH_EXCESS  = 11'b100_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [3:0]  field_code;
    logic [15:0] field_offset;
    logic [7:0]  byte_out;
    logic        message_done;
    logic [1:0]  parse_status;
    logic [15:0] version_word;
    logic [7:0]  session_length;
    logic [15:0] cipher_code;
    logic        cipher_known;
    logic [7:0]  compression_code;
  } out_beat_t;

  // Field tag that a byte gets in a given phase
  function automatic field_e field_of(input phase_e ph);
    field_e f;
    unique case (ph)
      PH_VERSION: f = FLD_VERSION;
      PH_TIME:    f = FLD_TIME;
      PH_RANDOM:  f = FLD_RANDOM;
      PH_SIDLEN:  f = FLD_SIDLEN;
      PH_SID:     f = FLD_SID;
      PH_CIPHER:  f = FLD_CIPHER;
      PH_COMP:    f = FLD_COMP;
      PH_EXTLEN:  f = FLD_EXTLEN;
      PH_EXTHDR:  f = FLD_EXTHDR;
      PH_EXTBODY: f = FLD_EXTBODY;
      PH_EXCESS:  f = FLD_EXCESS;
      default:    f = FLD_EXCESS;
    endcase
    return f;
  endfunction

endpackage

[rtl/core/tls_server_hello_parser_top.sv]
// ServerHello body parser, top level: phase tracker, counters and result register.
// Depends on tshp_pkg for beat structs, phase and code enums and constants.
`timescale 1ns / 1ps
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------------
//  in      | sink      | in_valid_i / in_stall_o  | in_beat_i  (byte, last flag)
//  out     | source    | out_valid_o / out_stall_i| out_beat_o (tag, offset,
//          |           |                         |  byte, summary on last beat)
//
//  One beat in gives one beat out in the cycle after: the phase and counter update
//  and the result are computed combinationally into the result register.
//  A new byte is taken every cycle while the result register is empty or is
//  being drained in the same cycle, so the sustained rate is one byte per cycle.
//  Input stall follows output stall only while a result is held.
//  Reset returns the parser to the version phase with all counters cleared;
//  the beat flagged last does the same after its summary is formed.

module tls_server_hello_parser_top
  import tshp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_beat_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_beat_o
);

  // Parser state
  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [7:0]  sid_q, sid_d;
  logic [15:0] list_q, list_d;
  logic [15:0] body_q, body_d;
  logic [15:0] ver_q, ver_d;
  logic [15:0] ciph_q, ciph_d;
  logic [7:0]  comp_q, comp_d;
  logic [1:0]  err_q, err_d;

  // Result register
  logic      out_valid_q;
  out_beat_t out_beat_q, out_beat_d;

  logic in_fire;
  logic out_fire;

  // Hold the input while a result waits and the sink stalls
  assign out_fire   = out_valid_q & ~out_stall_i;
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] cnt_inc;
    logic [15:0] off;
    field_e      fld;
    logic [1:0]  set_code;
    logic        go_excess;
    logic        complete;
    status_e     status;

    b         = in_beat_i.byte_value;
    cnt_inc   = cnt_q + 16'd1;
    off       = cnt_q;
    fld       = field_of(phase_q);
    set_code  = ST_OK;
    go_excess = 1'b0;
    complete  = 1'b0;
    status    = ST_OK;

    phase_d = phase_q;
    cnt_d   = cnt_q;
    sid_d   = sid_q;
    list_d  = list_q;
    body_d  = body_q;
    ver_d   = ver_q;
    ciph_d  = ciph_q;
    comp_d  = comp_q;
    err_d   = err_q;

    unique case (phase_q)
      PH_VERSION: begin
        ver_d = {ver_q[7:0], b};
        cnt_d = cnt_inc;
        if (cnt_inc >= VERSION_BYTES) begin
          phase_d = PH_TIME;
          cnt_d   = '0;
        end
      end
      PH_TIME: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= TIME_BYTES) begin
          phase_d = PH_RANDOM;
          cnt_d   = '0;
        end
      end
      PH_RANDOM: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= RANDOM_LEN) begin
          phase_d = PH_SIDLEN;
          cnt_d   = '0;
        end
      end
      PH_SIDLEN: begin
        sid_d = b;
        if (b > MAX_SESSION_ID) begin
          set_code = ST_SID_LONG;
        end
        phase_d = (b == 8'd0) ? PH_CIPHER : PH_SID;
        cnt_d   = '0;
      end
      PH_SID: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= {8'd0, sid_q}) begin
          phase_d = PH_CIPHER;
          cnt_d   = '0;
        end
      end
      PH_CIPHER: begin
        ciph_d = {ciph_q[7:0], b};
        cnt_d  = cnt_inc;
        if (cnt_inc >= CIPHER_BYTES) begin
          phase_d = PH_COMP;
          cnt_d   = '0;
        end
      end
      PH_COMP: begin
        comp_d  = b;
        phase_d = PH_EXTLEN;
        cnt_d   = '0;
      end
      PH_EXTLEN: begin
        list_d = {list_q[7:0], b};
        cnt_d  = cnt_inc;
        if (cnt_inc >= EXTLEN_BYTES) begin
          phase_d = PH_EXTHDR;
          cnt_d   = '0;
        end
      end
      PH_EXTHDR: begin
        if (list_q == 16'd0) begin
          go_excess = 1'b1;
        end else begin
          list_d = list_q - 16'd1;
          // Type bytes are skipped; the length bytes shift into the body count
          if (cnt_q >= EXTHDR_LEN_POS) begin
            body_d = {body_q[7:0], b};
          end
          cnt_d = cnt_inc;
          if (cnt_inc >= EXTHDR_BYTES) begin
            cnt_d = '0;
            if (body_d > list_d) begin
              set_code = ST_EXT_LEN;
            end
            phase_d = (body_d == 16'd0) ? PH_EXTHDR : PH_EXTBODY;
          end
        end
      end
      PH_EXTBODY: begin
        if (list_q == 16'd0) begin
          go_excess = 1'b1;
        end else begin
          list_d = list_q - 16'd1;
          if (body_q != 16'd0) begin
            body_d = body_q - 16'd1;
          end
          cnt_d = cnt_inc;
          if (body_d == 16'd0) begin
            phase_d = PH_EXTHDR;
            cnt_d   = '0;
          end
        end
      end
      PH_EXCESS: begin
        set_code = ST_EXT_LEN;
        if (cnt_q != OFFSET_MAX) begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        go_excess = 1'b1;
      end
    endcase

    // Bytes past the extension list: tag as excess and flag a length mismatch
    if (go_excess) begin
      fld      = FLD_EXCESS;
      off      = '0;
      phase_d  = PH_EXCESS;
      cnt_d    = 16'd1;
      set_code = ST_EXT_LEN;
    end

    // First error wins
    if (err_q == ST_OK) begin
      err_d = set_code;
    end

    out_beat_d                  = '0;
    out_beat_d.field_code       = fld;
    out_beat_d.field_offset     = off;
    out_beat_d.byte_out         = b;

    if (in_beat_i.last_byte) begin
      complete = ((phase_d == PH_EXTLEN) && (cnt_d == 16'd0)) ||
                 ((phase_d == PH_EXTHDR) && (cnt_d == 16'd0) && (list_d == 16'd0));
      if (err_d != ST_OK) begin
        status = status_e'(err_d);
      end else if (complete) begin
        status = ST_OK;
      end else begin
        status = ST_TRUNCATED;
      end
      out_beat_d.message_done     = 1'b1;
      out_beat_d.parse_status     = status;
      out_beat_d.version_word     = ver_d;
      out_beat_d.session_length   = sid_d;
      out_beat_d.cipher_code      = ciph_d;
      out_beat_d.cipher_known     = (ciph_d == CIPHER_RC4_SHA) ||
                                    (ciph_d == CIPHER_AES128_SHA) ||
                                    (ciph_d == CIPHER_AES256_SHA);
      out_beat_d.compression_code = comp_d;

      // Rearm for the next message
      phase_d = PH_VERSION;
      cnt_d   = '0;
      sid_d   = '0;
      list_d  = '0;
      body_d  = '0;
      ver_d   = '0;
      ciph_d  = '0;
      comp_d  = '0;
      err_d   = ST_OK;
    end
  end

  // Advance parser state on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VERSION;
      cnt_q   <= '0;
      sid_q   <= '0;
      list_q  <= '0;
      body_q  <= '0;
      ver_q   <= '0;
      ciph_q  <= '0;
      comp_q  <= '0;
      err_q   <= ST_OK;
    end else if (in_fire) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sid_q   <= sid_d;
      list_q  <= list_d;
      body_q  <= body_d;
      ver_q   <= ver_d;
      ciph_q  <= ciph_d;
      comp_q  <= comp_d;
      err_q   <= err_d;
    end
  end

  // Result valid: set on an accepted beat, drop once the sink takes it and no new beat is accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: load on accept, hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_beat_q <= out_beat_d;
    end
  end

endmodule
